FILE: rtl/core/ppim_pkg.sv
package ppim_pkg;

  // access kind codes
  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  // window offsets
  localparam logic [1:0] OFF_PORT_A = 2'd0;
  localparam logic [1:0] OFF_PORT_B = 2'd1;
  localparam logic [1:0] OFF_PORT_C = 2'd2;
  localparam logic [1:0] OFF_CTRL   = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_WINDOW_BASE = 2'd0;
  localparam logic [1:0] CFG_PIN_A       = 2'd1;
  localparam logic [1:0] CFG_PIN_B       = 2'd2;
  localparam logic [1:0] CFG_PIN_C       = 2'd3;

  // control word constants
  localparam logic [7:0] CTRL_RESET   = 8'h9B;
  localparam int unsigned CTRL_MODESET_BIT = 7;
  localparam int unsigned CTRL_A_IN_BIT    = 4;
  localparam int unsigned CTRL_CHI_IN_BIT  = 3;
  localparam int unsigned CTRL_B_IN_BIT    = 1;
  localparam int unsigned CTRL_CLO_IN_BIT  = 0;
  localparam logic [7:0] NIB_HI       = 8'hF0;
  localparam logic [7:0] NIB_LO       = 8'h0F;
  localparam logic [2:0] BIT_SEL      = 3'h7;

  typedef struct packed {
    logic       kind;
    logic [7:0] io_address;
    logic [7:0] write_data;
  } req_t;

  typedef struct packed {
    logic       read_hit;
    logic [7:0] read_data;
    logic [7:0] latch_a;
    logic [7:0] latch_b;
    logic [7:0] latch_c;
  } rsp_t;

  typedef struct packed {
    logic [7:0] window_base;
    logic [7:0] pin_a;
    logic [7:0] pin_b;
    logic [7:0] pin_c;
  } cfg_t;

endpackage

FILE: rtl/core/parallel_port_interface_mode0_core.sv
// Mode-0 parallel port core: three 8-bit ports and a control word in a
// four-address I/O window starting at the configured base address.
// Input channel (in_valid_i/in_ready_o/in_data_i): one bus read or write
// transaction per item. Output channel (out_valid_o/out_ready_i/out_data_o):
// exactly one result per transaction, in order: read hit, read data and the
// three output latches after the access.
// Path: an accepted transaction goes through the input register, then decode
// and port state update into the result register.
// Throughput: one transaction per cycle while the receiver keeps out_ready_i
// high; the input register and the result register are each a full stage, so a
// new transaction is taken while a finished result still waits.
// Receiver stall: the result register holds, then the input register fills,
// and only then does in_ready_o drop.
// Configuration: cfg_we_i writes window base or a pin value, taken at once.
// Reset: control word returns to all-input, latches and config registers to
// zero, both stages empty.
module parallel_port_interface_mode0_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  ppim_pkg::req_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output ppim_pkg::rsp_t out_data_o,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_idx_i,
  input  logic [7:0]     cfg_wdata_i
);

  ppim_pkg::cfg_t cfg_q;
  logic           s1_valid_q;
  ppim_pkg::req_t s1_req_q;
  logic           out_valid_q;
  ppim_pkg::rsp_t out_q;
  ppim_pkg::rsp_t rsp;
  logic           out_free;
  logic           s1_move;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ppim_pkg::CFG_WINDOW_BASE: cfg_q.window_base <= cfg_wdata_i;
        ppim_pkg::CFG_PIN_A:       cfg_q.pin_a       <= cfg_wdata_i;
        ppim_pkg::CFG_PIN_B:       cfg_q.pin_b       <= cfg_wdata_i;
        default:                   cfg_q.pin_c       <= cfg_wdata_i;
      endcase
    end
  end

  // stage handshake
  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_move    = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_req_q <= in_data_i;
    end
  end

  // decode and port state
  ppim_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (s1_move),
    .req_i  (s1_req_q),
    .cfg_i  (cfg_q),
    .rsp_o  (rsp)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // a transaction leaving the input register lands in the result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_move |=> out_valid_q)
    else $error("transaction lost between stages");

  // input side only stalls when both stages are occupied
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid_q && out_valid_q && !out_ready_i))
    else $error("input stalled with a free stage");

  // no read data without a window hit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.read_hit) |-> (out_q.read_data == 8'd0))
    else $error("read data on a miss or write");

endmodule

FILE: rtl/core/ppim_regs.sv
module ppim_regs (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  ppim_pkg::req_t req_i,
  input  ppim_pkg::cfg_t cfg_i,
  output ppim_pkg::rsp_t rsp_o
);

  logic [7:0] ctrl_q, ctrl_d;
  logic [7:0] latch_a_q, latch_a_d;
  logic [7:0] latch_b_q, latch_b_d;
  logic [7:0] latch_c_q, latch_c_d;

  logic [8:0] diff;
  logic       in_win;
  logic [1:0] off;
  logic [7:0] port_c_val;
  logic [7:0] rd_val;
  logic [7:0] bit_mask;

  // window decode, no wrap past the top of the address space
  assign diff   = {1'b0, req_i.io_address} - {1'b0, cfg_i.window_base};
  assign in_win = !diff[8] && (diff[7:2] == 6'd0);
  assign off    = diff[1:0];

  // port c mixes its two nibbles
  assign port_c_val =
    ((ctrl_q[ppim_pkg::CTRL_CHI_IN_BIT] ? cfg_i.pin_c : latch_c_q) & ppim_pkg::NIB_HI) |
    ((ctrl_q[ppim_pkg::CTRL_CLO_IN_BIT] ? cfg_i.pin_c : latch_c_q) & ppim_pkg::NIB_LO);

  // read mux
  always_comb begin
    unique case (off)
      ppim_pkg::OFF_PORT_A:
        rd_val = ctrl_q[ppim_pkg::CTRL_A_IN_BIT] ? cfg_i.pin_a : latch_a_q;
      ppim_pkg::OFF_PORT_B:
        rd_val = ctrl_q[ppim_pkg::CTRL_B_IN_BIT] ? cfg_i.pin_b : latch_b_q;
      ppim_pkg::OFF_PORT_C: rd_val = port_c_val;
      default:              rd_val = ctrl_q;
    endcase
  end

  assign bit_mask = 8'd1 << (req_i.write_data[3:1] & ppim_pkg::BIT_SEL);

  // write decode
  always_comb begin
    ctrl_d    = ctrl_q;
    latch_a_d = latch_a_q;
    latch_b_d = latch_b_q;
    latch_c_d = latch_c_q;
    if (en_i && in_win && (req_i.kind == ppim_pkg::KIND_WRITE)) begin
      unique case (off)
        ppim_pkg::OFF_PORT_A: latch_a_d = req_i.write_data;
        ppim_pkg::OFF_PORT_B: latch_b_d = req_i.write_data;
        ppim_pkg::OFF_PORT_C: latch_c_d = req_i.write_data;
        default: begin
          if (req_i.write_data[ppim_pkg::CTRL_MODESET_BIT]) begin
            ctrl_d    = req_i.write_data;
            latch_a_d = '0;
            latch_b_d = '0;
            latch_c_d = '0;
          end else if (req_i.write_data[0]) begin
            latch_c_d = latch_c_q | bit_mask;
          end else begin
            latch_c_d = latch_c_q & ~bit_mask;
          end
        end
      endcase
    end
  end

  // port state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q    <= ppim_pkg::CTRL_RESET;
      latch_a_q <= '0;
      latch_b_q <= '0;
      latch_c_q <= '0;
    end else begin
      ctrl_q    <= ctrl_d;
      latch_a_q <= latch_a_d;
      latch_b_q <= latch_b_d;
      latch_c_q <= latch_c_d;
    end
  end

  // result reflects latches after the access
  always_comb begin
    rsp_o.read_hit  = in_win && (req_i.kind == ppim_pkg::KIND_READ);
    rsp_o.read_data = rsp_o.read_hit ? rd_val : 8'd0;
    rsp_o.latch_a   = latch_a_d;
    rsp_o.latch_b   = latch_b_d;
    rsp_o.latch_c   = latch_c_d;
  end

endmodule
